// ===== design/fpi_pkg.sv =====
// ----------------------------------------------------------------------------
// fpi_pkg
// Shared types, constants and the Gaussian membership table of the fuzzy
// PD inference unit.
// ----------------------------------------------------------------------------
package fpi_pkg;

  localparam int unsigned MaxRulesDefault = 16;
  localparam int unsigned MuRomSize       = 256;
  localparam int unsigned MuWidth         = 16;
  localparam int unsigned QuoWidth        = 17;
  localparam logic [63:0] MuRQ31          = 64'd2146290933;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_EVAL   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_ZERO_WGHT = 2'd2,
    STAT_RSVD      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_DIV  = 2'd2
  } state_e;

  typedef struct packed {
    logic signed [7:0] ec;
    logic signed [7:0] dc;
    logic              comb;
    logic signed [7:0] outv;
  } rule_t;

  typedef logic [MuWidth-1:0] mu_rom_t [MuRomSize];

  function automatic mu_rom_t build_mu_rom();
    mu_rom_t     rom;
    logic [63:0] g;
    logic [63:0] q;
    logic [63:0] r2;
    logic [63:0] v;
    g  = 64'd1 << 31;
    q  = MuRQ31;
    r2 = (MuRQ31 * MuRQ31) >> 31;
    for (int d = 0; d < MuRomSize; d++) begin
      v = (g + (64'd1 << 14)) >> 15;
      rom[d] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      g = (g * q) >> 31;
      q = (q * r2) >> 31;
    end
    return rom;
  endfunction

  localparam mu_rom_t MuRom = build_mu_rom();

  function automatic logic [MuWidth-1:0] member(logic signed [7:0] x,
                                                logic signed [7:0] c);
    logic signed [8:0] d;
    logic [8:0]        a;
    d = 9'(x) - 9'(c);
    a = d[8] ? 9'(-d) : 9'(d);
    return MuRom[a[7:0]];
  endfunction

endpackage

// ===== design/fpi_ram.sv =====
// ----------------------------------------------------------------------------
// fpi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fpi_div.sv =====
// ----------------------------------------------------------------------------
// fpi_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// QuoWidth bits.
// ----------------------------------------------------------------------------
module fpi_div #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 22
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [NumW-1:0]                  num_i,
  input  logic [DenW-1:0]                  den_i,
  output logic                             done_o,
  output logic [fpi_pkg::QuoWidth-1:0]     quo_o
);

  localparam int unsigned QW = fpi_pkg::QuoWidth;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [QW-1:0]   nlo_q;
  logic [QW-1:0]   quo_q, quo_d;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [DenW:0]   rem_sh;
  logic            qbit;

  assign rem_sh = {rem_q, nlo_q[QW-1]};
  assign qbit   = rem_sh >= {1'b0, den_q};
  assign rem_d  = qbit ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
  assign quo_d  = {quo_q[QW-2:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(QW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DenW'(num_i >> QW);
      nlo_q <= num_i[QW-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= rem_d;
      nlo_q <= {nlo_q[QW-2:0], 1'b0};
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== design/fuzzy_pd_inference_unit.sv =====
// ----------------------------------------------------------------------------
// fuzzy_pd_inference_unit
// Zero-order Sugeno fuzzy PD controller with a rule table in RAM.
// ----------------------------------------------------------------------------
// Clear, append and unused commands: result strobe one cycle after start.
// Evaluate: one rule read per cycle; each rule passes the RAM read register and
// the weight register into the sums, then the divider forms the result; zero
// total weight skips the divider. busy_o holds until the strobe cycle.
// Reset empties the rule table (count to zero); table RAM is not cleared.
module fuzzy_pd_inference_unit #(
  parameter int unsigned MaxRules = fpi_pkg::MaxRulesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        cmd_i,
  input  logic signed [7:0] err_value_i,
  input  logic signed [7:0] derr_value_i,
  input  logic signed [7:0] rule_err_center_i,
  input  logic signed [7:0] rule_derr_center_i,
  input  logic              rule_combine_i,
  input  logic signed [7:0] rule_out_value_i,
  output logic              done_o,
  output logic signed [15:0] conclusion_o,
  output logic [1:0]        status_o,
  output logic [4:0]        rules_held_o
);

  localparam int unsigned CW = $clog2(MaxRules + 1);
  localparam int unsigned AW = (MaxRules > 1) ? $clog2(MaxRules) : 1;
  localparam int unsigned WW = fpi_pkg::MuWidth + CW;
  localparam int unsigned SW = 25 + CW;
  localparam int unsigned NW = SW + 10;
  localparam int unsigned DW = WW + 1;
  localparam int unsigned QW = fpi_pkg::QuoWidth;

  fpi_pkg::state_e state_q, state_d;

  logic [CW-1:0]        count_q, idx_q;
  logic signed [7:0]    err_q, derr_q;
  logic                 rd_vld_q, w1_vld_q;
  logic [15:0]          w1_q;
  logic signed [7:0]    out1_q;
  logic signed [SW-1:0] s_q;
  logic [WW-1:0]        wsum_q;
  logic                 neg_q;
  logic                 done_q;
  logic signed [15:0]   concl_q;
  logic [1:0]           status_q;

  logic                 accept, issue, drained, div_start, div_done;
  logic                 ram_we;
  fpi_pkg::rule_t       wrule, rrule;
  logic [15:0]          me, md, wgt;
  logic signed [24:0]   prod;
  logic [SW-1:0]        mag;
  logic [NW-1:0]        num;
  logic [DW-1:0]        den;
  logic [QW-1:0]        quo;
  logic signed [15:0]   concl_div;

  assign accept  = start_i && (state_q == fpi_pkg::ST_IDLE);
  assign issue   = (state_q == fpi_pkg::ST_EVAL) && (idx_q < count_q);
  assign drained = !issue && !rd_vld_q && !w1_vld_q;
  assign ram_we  = accept && (fpi_pkg::cmd_e'(cmd_i) == fpi_pkg::CMD_APPEND)
                   && (count_q < CW'(MaxRules));

  assign wrule.ec   = rule_err_center_i;
  assign wrule.dc   = rule_derr_center_i;
  assign wrule.comb = rule_combine_i;
  assign wrule.outv = rule_out_value_i;

  fpi_ram #(
    .Width ($bits(fpi_pkg::rule_t)),
    .Depth (MaxRules)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wrule),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rrule)
  );

  assign me   = fpi_pkg::member(err_q, rrule.ec);
  assign md   = fpi_pkg::member(derr_q, rrule.dc);
  assign wgt  = rrule.comb ? ((me > md) ? me : md) : ((me < md) ? me : md);
  assign prod = $signed({1'b0, w1_q}) * out1_q;

  assign mag = s_q[SW-1] ? SW'(-s_q) : SW'(s_q);
  assign num = (NW'(mag) << 9) + NW'(wsum_q);
  assign den = {wsum_q, 1'b0};

  fpi_div #(
    .NumW (NW),
    .DenW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    if (neg_q) begin
      concl_div = (quo > QW'(32768)) ? 16'sh8000 : 16'(-$signed({1'b0, quo}));
    end else begin
      concl_div = (quo > QW'(32767)) ? 16'sh7FFF : 16'(quo);
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      fpi_pkg::ST_IDLE: begin
        if (accept && (fpi_pkg::cmd_e'(cmd_i) == fpi_pkg::CMD_EVAL)) begin
          state_d = fpi_pkg::ST_EVAL;
        end
      end
      fpi_pkg::ST_EVAL: begin
        if (drained) begin
          if (wsum_q == '0) begin
            state_d = fpi_pkg::ST_IDLE;
          end else begin
            div_start = 1'b1;
            state_d   = fpi_pkg::ST_DIV;
          end
        end
      end
      fpi_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = fpi_pkg::ST_IDLE;
        end
      end
      default: state_d = fpi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fpi_pkg::ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      w1_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      w1_vld_q <= rd_vld_q;
      done_q   <= 1'b0;
      if (issue) begin
        idx_q <= idx_q + 1'b1;
      end
      if (accept) begin
        idx_q <= '0;
        case (fpi_pkg::cmd_e'(cmd_i))
          fpi_pkg::CMD_CLEAR: begin
            count_q <= '0;
            done_q  <= 1'b1;
          end
          fpi_pkg::CMD_APPEND: begin
            if (ram_we) begin
              count_q <= count_q + 1'b1;
            end
            done_q <= 1'b1;
          end
          fpi_pkg::CMD_EVAL: begin
            done_q <= 1'b0;
          end
          default: done_q <= 1'b1;
        endcase
      end
      if ((state_q == fpi_pkg::ST_EVAL && drained && wsum_q == '0)
          || (state_q == fpi_pkg::ST_DIV && div_done)) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      w1_q   <= wgt;
      out1_q <= rrule.outv;
    end
    if (w1_vld_q) begin
      s_q    <= s_q + SW'(prod);
      wsum_q <= wsum_q + WW'(w1_q);
    end
    if (div_start) begin
      neg_q <= s_q[SW-1];
    end
    if (accept) begin
      err_q    <= err_value_i;
      derr_q   <= derr_value_i;
      s_q      <= '0;
      wsum_q   <= '0;
      concl_q  <= '0;
      status_q <= fpi_pkg::STAT_OK;
      if ((fpi_pkg::cmd_e'(cmd_i) == fpi_pkg::CMD_APPEND) && !ram_we) begin
        status_q <= fpi_pkg::STAT_FULL;
      end
    end
    if (state_q == fpi_pkg::ST_EVAL && drained && wsum_q == '0) begin
      status_q <= fpi_pkg::STAT_ZERO_WGHT;
    end
    if (state_q == fpi_pkg::ST_DIV && div_done) begin
      concl_q <= concl_div;
    end
  end

  assign busy_o       = (state_q != fpi_pkg::ST_IDLE);
  assign done_o       = done_q;
  assign conclusion_o = concl_q;
  assign status_o     = status_q;
  assign rules_held_o = 5'(count_q);

endmodule
